>>> rtl/hysteretic_grip_ramp_macros.svh
// assertion macros shared by the rtl files
// each macro expects signals named clk and rst_n in the enclosing module
`ifndef HYSTERETIC_GRIP_RAMP_MACROS_SVH
`define HYSTERETIC_GRIP_RAMP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define HGR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgr assertion failed");

// next-cycle implication
`define HGR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgr assertion failed");

`else

`define HGR_ASSERT_IMP(label, ante, cons)
`define HGR_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/hgr_pkg.sv
package hgr_pkg;

  // hand state codes
  localparam logic [1:0] MODE_OPEN    = 2'd0;
  localparam logic [1:0] MODE_CLOSING = 2'd1;
  localparam logic [1:0] MODE_OPENING = 2'd2;
  localparam logic [1:0] MODE_HOLDING = 2'd3;

  // fixed opening step, one degree (256 units of 1/256 degree) per update
  localparam logic [15:0] OPEN_STEP = 16'd256;

  // angle reset values (hand fully open)
  localparam logic [15:0] CLOSE_ANGLE_RST = 16'd0;
  localparam logic [15:0] OPEN_ANGLE_RST  = 16'd46080;

  // register indexes on the config port
  localparam logic [2:0] REG_ENGAGE       = 3'd0;
  localparam logic [2:0] REG_RELEASE      = 3'd1;
  localparam logic [2:0] REG_GAIN         = 3'd2;
  localparam logic [2:0] REG_STEP_CAP     = 3'd3;
  localparam logic [2:0] REG_CLOSE_OPEN   = 3'd4;
  localparam logic [2:0] REG_CLOSE_CLOSED = 3'd5;
  localparam logic [2:0] REG_OPEN_OPEN    = 3'd6;
  localparam logic [2:0] REG_OPEN_CLOSED  = 3'd7;

  // settings used by the step stage
  typedef struct packed {
    logic [15:0] engage_thr;
    logic [15:0] release_thr;
    logic [15:0] speed_gain;
    logic [15:0] step_cap;
  } hgr_rate_cfg_t;

  // servo angle limits
  typedef struct packed {
    logic [15:0] close_open;
    logic [15:0] close_closed;
    logic [15:0] open_open;
    logic [15:0] open_closed;
  } hgr_limit_t;

  // move command from the step stage to the servo stage
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] step;
  } hgr_cmd_t;

endpackage

>>> rtl/hgr_speed.sv
module hgr_speed (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_signal_ratio,
  input  hgr_pkg::hgr_rate_cfg_t rate_cfg,
  output logic                  cmd_valid,
  output hgr_pkg::hgr_cmd_t     cmd,
  input  logic                  cmd_ready
);
  import hgr_pkg::*;

  logic        a_valid_r;
  logic [15:0] ratio_r;
  logic        cmd_valid_r;
  hgr_cmd_t    cmd_r;
  hgr_cmd_t    cmd_nxt;
  logic        a_ready;
  logic        b_ready;
  logic [15:0] diff;
  logic [31:0] prod;
  logic [23:0] raw_speed;
  logic [15:0] speed;

  // stage flow control
  assign b_ready  = !cmd_valid_r || cmd_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_stall = !a_ready;

  // closing speed: excess ratio times gain, capped
  assign diff      = ratio_r - rate_cfg.engage_thr;
  assign prod      = diff * rate_cfg.speed_gain;
  assign raw_speed = prod[31:8];
  assign speed     = (raw_speed > {8'd0, rate_cfg.step_cap}) ? rate_cfg.step_cap
                                                              : raw_speed[15:0];

  // hysteresis decision, closing test first
  always_comb begin
    priority if (ratio_r > rate_cfg.engage_thr) begin
      cmd_nxt.mode = MODE_CLOSING;
      cmd_nxt.step = speed;
    end else if (ratio_r < rate_cfg.release_thr) begin
      cmd_nxt.mode = MODE_OPENING;
      cmd_nxt.step = OPEN_STEP;
    end else begin
      cmd_nxt.mode = MODE_HOLDING;
      cmd_nxt.step = 16'd0;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      cmd_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        cmd_valid_r <= a_valid_r;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      ratio_r <= in_signal_ratio;
    end
    if (b_ready && a_valid_r) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

endmodule

>>> rtl/hgr_servo.sv
`include "hysteretic_grip_ramp_macros.svh"

module hgr_servo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  input  hgr_pkg::hgr_cmd_t  cmd,
  output logic               cmd_ready,
  input  hgr_pkg::hgr_limit_t limits,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_hand_state,
  output logic [15:0]        out_close_servo_angle,
  output logic [15:0]        out_open_servo_angle,
  output logic               out_angles_written
);
  import hgr_pkg::*;

  logic        out_valid_r;
  logic [1:0]  hand_state_r;
  logic        written_r;
  logic [15:0] close_angle_r;
  logic [15:0] open_angle_r;
  logic [15:0] close_angle_nxt;
  logic [15:0] open_angle_nxt;
  logic        written_nxt;
  logic        out_ready;
  logic        fire;

  // add, then clamp from above
  function automatic logic [15:0] sat_add_min(input logic [15:0] a, input logic [15:0] step,
                                              input logic [15:0] limit);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, step};
    return (sum < {1'b0, limit}) ? sum[15:0] : limit;
  endfunction

  // subtract, then clamp from below
  function automatic logic [15:0] sat_sub_max(input logic [15:0] a, input logic [15:0] step,
                                              input logic [15:0] limit);
    logic [16:0] diff;
    diff = {1'b0, a} - {1'b0, step};
    if (diff[16]) begin
      return limit;
    end
    return (diff[15:0] > limit) ? diff[15:0] : limit;
  endfunction

  assign out_ready = !out_valid_r || !out_stall;
  assign cmd_ready = out_ready;
  assign fire      = cmd_valid && out_ready;

  // angle update
  always_comb begin
    unique case (cmd.mode)
      MODE_CLOSING: begin
        close_angle_nxt = sat_add_min(close_angle_r, cmd.step, limits.close_closed);
        open_angle_nxt  = sat_sub_max(open_angle_r, cmd.step, limits.open_closed);
      end
      MODE_OPENING: begin
        close_angle_nxt = sat_sub_max(close_angle_r, cmd.step, limits.close_open);
        open_angle_nxt  = sat_add_min(open_angle_r, cmd.step, limits.open_open);
      end
      default: begin
        close_angle_nxt = close_angle_r;
        open_angle_nxt  = open_angle_r;
      end
    endcase
  end

  assign written_nxt = (cmd.mode == MODE_CLOSING) || (cmd.mode == MODE_OPENING);

  // angle state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      close_angle_r <= CLOSE_ANGLE_RST;
      open_angle_r  <= OPEN_ANGLE_RST;
    end else begin
      if (out_ready) begin
        out_valid_r <= cmd_valid;
      end
      if (fire) begin
        close_angle_r <= close_angle_nxt;
        open_angle_r  <= open_angle_nxt;
      end
    end
  end

  // result flags
  always_ff @(posedge clk) begin
    if (fire) begin
      hand_state_r <= cmd.mode;
      written_r    <= written_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hand_state        = hand_state_r;
  assign out_close_servo_angle = close_angle_r;
  assign out_open_servo_angle  = open_angle_r;
  assign out_angles_written    = written_r;

  // holding leaves both angles alone
  `HGR_ASSERT_NXT(a_hold_keeps_angles, fire && (cmd.mode == MODE_HOLDING), $stable(close_angle_r) && $stable(open_angle_r))
  // closing never passes the closed limits
  `HGR_ASSERT_NXT(a_close_within_limits, fire && (cmd.mode == MODE_CLOSING), (close_angle_r <= $past(limits.close_closed)) && (open_angle_r >= $past(limits.open_closed)))
  // opening never passes the open limits
  `HGR_ASSERT_NXT(a_open_within_limits, fire && (cmd.mode == MODE_OPENING), (close_angle_r >= $past(limits.close_open)) && (open_angle_r <= $past(limits.open_open)))

endmodule

>>> rtl/hysteretic_grip_ramp.sv
// channel  | handshake                          | payload
// ---------+------------------------------------+---------------------------------------
// input    | in_valid / in_stall                | in_signal_ratio
// result   | out_valid / out_stall              | out_hand_state, out_close_servo_angle,
//          |                                    | out_open_servo_angle, out_angles_written
// config   | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// one item per cycle sustained while out_stall is low
// stages: input register, step register (multiplier and cap), angle/result register
// the next item sees the angles left by the previous one with no bubble
// reset: settings to their defaults, angles to the fully open position, pipeline empty
// out_stall holds the result; in_stall rises only once all three stages are full
`include "hysteretic_grip_ramp_macros.svh"

module hysteretic_grip_ramp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_signal_ratio,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_hand_state,
  output logic [15:0] out_close_servo_angle,
  output logic [15:0] out_open_servo_angle,
  output logic        out_angles_written,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hgr_pkg::*;

  logic [15:0]   engage_r;
  logic [15:0]   release_r;
  logic [15:0]   gain_r;
  logic [15:0]   step_cap_r;
  logic [15:0]   close_open_r;
  logic [15:0]   close_closed_r;
  logic [15:0]   open_open_r;
  logic [15:0]   open_closed_r;
  logic [2:0]    reg_idx;
  logic          cfg_wr;
  logic [15:0]   rd_val;
  hgr_rate_cfg_t rate_cfg;
  hgr_limit_t    limits;
  logic          cmd_valid;
  hgr_cmd_t      cmd;
  logic          cmd_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engage_r       <= 16'd384;
      release_r      <= 16'd307;
      gain_r         <= 16'd1707;
      step_cap_r     <= 16'd2560;
      close_open_r   <= 16'd0;
      close_closed_r <= 16'd23040;
      open_open_r    <= 16'd46080;
      open_closed_r  <= 16'd23040;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENGAGE:       engage_r       <= pwdata[15:0];
        REG_RELEASE:      release_r      <= pwdata[15:0];
        REG_GAIN:         gain_r         <= pwdata[15:0];
        REG_STEP_CAP:     step_cap_r     <= pwdata[15:0];
        REG_CLOSE_OPEN:   close_open_r   <= pwdata[15:0];
        REG_CLOSE_CLOSED: close_closed_r <= pwdata[15:0];
        REG_OPEN_OPEN:    open_open_r    <= pwdata[15:0];
        REG_OPEN_CLOSED:  open_closed_r  <= pwdata[15:0];
      endcase
    end
  end

  // config readback
  always_comb begin
    unique case (reg_idx)
      REG_ENGAGE:       rd_val = engage_r;
      REG_RELEASE:      rd_val = release_r;
      REG_GAIN:         rd_val = gain_r;
      REG_STEP_CAP:     rd_val = step_cap_r;
      REG_CLOSE_OPEN:   rd_val = close_open_r;
      REG_CLOSE_CLOSED: rd_val = close_closed_r;
      REG_OPEN_OPEN:    rd_val = open_open_r;
      REG_OPEN_CLOSED:  rd_val = open_closed_r;
    endcase
  end

  assign prdata = {16'd0, rd_val};

  assign rate_cfg.engage_thr  = engage_r;
  assign rate_cfg.release_thr = release_r;
  assign rate_cfg.speed_gain  = gain_r;
  assign rate_cfg.step_cap    = step_cap_r;

  assign limits.close_open   = close_open_r;
  assign limits.close_closed = close_closed_r;
  assign limits.open_open    = open_open_r;
  assign limits.open_closed  = open_closed_r;

  // ratio register and step computation
  hgr_speed u_speed (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_signal_ratio (in_signal_ratio),
    .rate_cfg        (rate_cfg),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_ready       (cmd_ready)
  );

  // angle update and result register
  hgr_servo u_servo (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd_valid             (cmd_valid),
    .cmd                   (cmd),
    .cmd_ready             (cmd_ready),
    .limits                (limits),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_hand_state        (out_hand_state),
    .out_close_servo_angle (out_close_servo_angle),
    .out_open_servo_angle  (out_open_servo_angle),
    .out_angles_written    (out_angles_written)
  );

  // angles are reported as written exactly when the hand state is not holding
  `HGR_ASSERT_IMP(a_written_matches_state, out_valid, out_angles_written == (out_hand_state != MODE_HOLDING))

endmodule

>>> test/tb_hysteretic_grip_ramp.sv
`timescale 1ns / 1ps

import hgr_pkg::*;

// one result as seen on the output channel
typedef struct packed {
  logic [1:0]  hand_state;
  logic [15:0] close_angle;
  logic [15:0] open_angle;
  logic        written;
} grip_result_t;

// kinds of ratio runs used by the random stimulus
typedef enum {RUN_CLOSE, RUN_OPEN, RUN_HOLD, RUN_EDGE, RUN_NOISE} ratio_run_t;

class grip_scoreboard;
  logic [15:0]  setting [8];
  logic [15:0]  close_angle;
  logic [15:0]  open_angle;
  grip_result_t pending_results [$];
  int           mismatches;
  int           checked;

  function new();
    setting[REG_ENGAGE]       = 16'd384;
    setting[REG_RELEASE]      = 16'd307;
    setting[REG_GAIN]         = 16'd1707;
    setting[REG_STEP_CAP]     = 16'd2560;
    setting[REG_CLOSE_OPEN]   = 16'd0;
    setting[REG_CLOSE_CLOSED] = 16'd23040;
    setting[REG_OPEN_OPEN]    = 16'd46080;
    setting[REG_OPEN_CLOSED]  = 16'd23040;
    close_angle = CLOSE_ANGLE_RST;
    open_angle  = OPEN_ANGLE_RST;
    mismatches  = 0;
    checked     = 0;
  endfunction

  function void write_setting(logic [2:0] idx, logic [15:0] value);
    setting[idx] = value;
  endfunction

  function int pending();
    return pending_results.size();
  endfunction

  // advance the hand by one ratio sample and queue the result it yields
  function void note_ratio(logic [15:0] ratio);
    longint       step;
    longint       next_close;
    longint       next_open;
    grip_result_t res;
    next_close = close_angle;
    next_open  = open_angle;
    if (ratio > setting[REG_ENGAGE]) begin
      // closing: proportional step, capped, each angle saturates at its closed limit
      step = ((longint'(ratio) - longint'(setting[REG_ENGAGE])) *
              longint'(setting[REG_GAIN])) >>> 8;
      if (step > longint'(setting[REG_STEP_CAP])) step = setting[REG_STEP_CAP];
      next_close = close_angle + step;
      if (next_close >= longint'(setting[REG_CLOSE_CLOSED]))
        next_close = setting[REG_CLOSE_CLOSED];
      next_open = open_angle - step;
      if (next_open <= longint'(setting[REG_OPEN_CLOSED]))
        next_open = setting[REG_OPEN_CLOSED];
      res.hand_state = MODE_CLOSING;
      res.written    = 1'b1;
    end else if (ratio < setting[REG_RELEASE]) begin
      // opening: fixed step toward the open limits
      next_close = close_angle - longint'(OPEN_STEP);
      if (next_close <= longint'(setting[REG_CLOSE_OPEN]))
        next_close = setting[REG_CLOSE_OPEN];
      next_open = open_angle + longint'(OPEN_STEP);
      if (next_open >= longint'(setting[REG_OPEN_OPEN]))
        next_open = setting[REG_OPEN_OPEN];
      res.hand_state = MODE_OPENING;
      res.written    = 1'b1;
    end else begin
      res.hand_state = MODE_HOLDING;
      res.written    = 1'b0;
    end
    close_angle     = next_close[15:0];
    open_angle      = next_open[15:0];
    res.close_angle = close_angle;
    res.open_angle  = open_angle;
    pending_results.push_back(res);
  endfunction

  // compare one result transfer against the oldest queued result
  function void check_result(grip_result_t got);
    grip_result_t want;
    checked++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: state %0d close %0d open %0d written %0d",
                 got.hand_state, got.close_angle, got.open_angle, got.written);
      return;
    end
    want = pending_results.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"result %0d mismatch (exp/got): state %0d/%0d close %0d/%0d",
                  " open %0d/%0d written %0d/%0d"},
                 checked, want.hand_state, got.hand_state, want.close_angle,
                 got.close_angle, want.open_angle, got.open_angle, want.written,
                 got.written);
    end
  endfunction
endclass

module tb_hysteretic_grip_ramp;

  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [15:0] in_signal_ratio = 16'd0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [1:0]  out_hand_state;
  logic [15:0] out_close_servo_angle;
  logic [15:0] out_open_servo_angle;
  logic        out_angles_written;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [4:0]  paddr           = 5'd0;
  logic [31:0] pwdata          = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  grip_scoreboard board = new();

  bit calm       = 1'b0;  // no idling on either side
  bit quiet      = 1'b0;  // sender runs without gaps for this phase
  int sent       = 0;
  int settings_n = 0;
  int idle_cycles = 0;

  hysteretic_grip_ramp u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_signal_ratio       (in_signal_ratio),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_hand_state        (out_hand_state),
    .out_close_servo_angle (out_close_servo_angle),
    .out_open_servo_angle  (out_open_servo_angle),
    .out_angles_written    (out_angles_written),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        board.check_result({out_hand_state, out_close_servo_angle,
                            out_open_servo_angle, out_angles_written});
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(30, 80)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!calm && rst_n) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // register write: setup phase, access phase until pready, then bus idle
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.write_setting(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] engage, input logic [15:0] release_r,
                           input logic [15:0] gain, input logic [15:0] max_spd,
                           input logic [15:0] c_open, input logic [15:0] c_closed,
                           input logic [15:0] o_open, input logic [15:0] o_closed);
    write_reg(REG_ENGAGE, engage);
    write_reg(REG_RELEASE, release_r);
    write_reg(REG_GAIN, gain);
    write_reg(REG_STEP_CAP, max_spd);
    write_reg(REG_CLOSE_OPEN, c_open);
    write_reg(REG_CLOSE_CLOSED, c_closed);
    write_reg(REG_OPEN_OPEN, o_open);
    write_reg(REG_OPEN_CLOSED, o_closed);
    settings_n++;
  endtask

  // one ratio transfer, with an occasional gap in front of it
  task automatic send_ratio(input logic [15:0] ratio);
    if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_signal_ratio <= ratio;
    do @(posedge clk); while (in_stall);
    board.note_ratio(ratio);
    sent++;
  endtask

  // sender pauses until every result is back, then lets the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_ratio(ratio_run_t kind);
    int e;
    int rl;
    int lo;
    int hi;
    e  = board.setting[REG_ENGAGE];
    rl = board.setting[REG_RELEASE];
    case (kind)
      RUN_CLOSE: if (e < 65535) begin
        lo = e + 1;
        hi = ($urandom_range(0, 1) == 1) ? 65535 : ((e + 512 > 65535) ? 65535 : e + 512);
        return 16'($urandom_range(hi, lo));
      end
      RUN_OPEN: if (rl > 0) begin
        hi = rl - 1;
        lo = ($urandom_range(0, 1) == 1) ? 0 : ((hi > 512) ? hi - 512 : 0);
        return 16'($urandom_range(hi, lo));
      end
      RUN_HOLD: if (rl <= e) return 16'($urandom_range(e, rl));
      RUN_EDGE: begin
        case ($urandom_range(0, 5))
          0: return 16'(e);
          1: return 16'(e + 1);
          2: return 16'(rl);
          3: return 16'(rl - 1);
          4: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      default: ;
    endcase
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 46080));
    endcase
  endfunction

  function automatic logic [15:0] pick_rate(int typical);
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, typical));
    endcase
  endfunction

  task automatic random_settings();
    logic [15:0] engage;
    logic [15:0] release_r;
    engage = pick_rate(2000);
    // release mostly below engage, sometimes crossed or arbitrary
    case ($urandom_range(0, 5))
      0: release_r = pick_rate(2000);
      1: release_r = 16'($urandom_range(65535, engage));
      default: release_r = 16'($urandom_range(engage, 0));
    endcase
    configure(engage, release_r, pick_rate(4000), pick_rate(8000),
              pick_limit(), pick_limit(), pick_limit(), pick_limit());
  endtask

  // runs of closing, opening or holding samples mixed with noise
  task automatic run_phase(input int count);
    int         left;
    int         len;
    int         pick;
    ratio_run_t kind;
    left = count;
    while (left > 0) begin
      pick = $urandom_range(0, 9);
      if (pick < 3)      kind = RUN_CLOSE;
      else if (pick < 6) kind = RUN_OPEN;
      else if (pick < 8) kind = RUN_HOLD;
      else if (pick < 9) kind = RUN_EDGE;
      else               kind = RUN_NOISE;
      len = $urandom_range(1, 25);
      if (len > left) len = left;
      repeat (len) send_ratio(pick_ratio(kind));
      left -= len;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: hold from the open state, thresholds and their neighbors,
    // capped closing, opening back to the limits
    send_ratio(16'd320);
    send_ratio(16'hffff);
    send_ratio(16'd384);
    send_ratio(16'd385);
    send_ratio(16'd307);
    send_ratio(16'd306);
    send_ratio(16'h0000);
    send_ratio(16'h0000);
    send_ratio(16'haaaa);
    send_ratio(16'h5555);
    drain_results();

    // crossed thresholds, full gain and cap, limits beyond the servo range
    configure(16'd0, 16'hffff, 16'hffff, 16'hffff,
              16'd0, 16'hffff, 16'hffff, 16'd0);
    send_ratio(16'hffff);
    send_ratio(16'h0000);
    send_ratio(16'd1);
    send_ratio(16'hffff);
    drain_results();

    // zero gain with limits moved inside the current angles: closing snaps them
    configure(16'd1000, 16'd500, 16'd0, 16'hffff,
              16'd30000, 16'd10000, 16'd20000, 16'd40000);
    send_ratio(16'hffff);
    send_ratio(16'd700);
    send_ratio(16'd0);
    drain_results();

    // zero cap with large gain
    configure(16'd1000, 16'd500, 16'hffff, 16'd0,
              16'd0, 16'd46080, 16'd46080, 16'd0);
    send_ratio(16'hffff);
    send_ratio(16'd1001);
    send_ratio(16'd499);
    drain_results();

    // random settings and ratio runs, with idling on both sides
    while (sent < 1450) begin
      random_settings();
      quiet = ($urandom_range(0, 3) == 0);
      run_phase($urandom_range(80, 200));
      drain_results();
    end

    // last stretch at full rate
    calm  = 1'b1;
    quiet = 1'b1;
    random_settings();
    run_phase(200);
    drain_results();
    repeat (10) @(posedge clk);

    $display("ratio samples: %0d over %0d register settings", sent, settings_n);
    $display("results checked: %0d, mismatches: %0d", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/hgr_pkg.sv
rtl/hgr_speed.sv
rtl/hgr_servo.sv
rtl/hysteretic_grip_ramp.sv
test/tb_hysteretic_grip_ramp.sv
